@@ hw/rtl/multi_resource_pool_allocator_unit_assert.svh @@
// Assertion macros used by the port-level checker of the pool allocator.
`ifndef MULTI_RESOURCE_POOL_ALLOCATOR_UNIT_ASSERT_SVH
`define MULTI_RESOURCE_POOL_ALLOCATOR_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, disabled while rst_n is low.
`define MRPA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pool allocator assertion failed");

// Next-cycle implication, sampled on clk, disabled while rst_n is low.
`define MRPA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pool allocator assertion failed");

`endif

@@ hw/rtl/mrpa_pkg.sv @@
// Package of the pool allocator: field widths, request codes, types and defaults.
package mrpa_pkg;

  localparam int NUM_RESOURCES_DEF = 16;
  localparam int MAX_NEEDS_DEF     = 8;

  localparam int TYPE_W  = 2;
  localparam int ID_W    = 8;
  localparam int COUNT_W = 16;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam logic [TYPE_W-1:0] REQ_ACQUIRE = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_RELEASE = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_SET     = 2'd2;

  // Classified entry as it travels from front to back.
  typedef struct packed {
    logic [TYPE_W-1:0]  req_type;
    logic               known;
    logic [ID_W-1:0]    idx;
    logic [COUNT_W-1:0] amount;
    logic               last;
  } entry_t;

  // Buffered acquire demand.
  typedef struct packed {
    logic               known;
    logic [ID_W-1:0]    idx;
    logic [COUNT_W-1:0] amount;
  } pend_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef enum logic [2:0] {
    BK_FETCH,
    BK_UPDATE,
    BK_START,
    BK_CHK_RD,
    BK_CHK_EX,
    BK_UNDO_RD,
    BK_UNDO_EX,
    BK_DONE
  } back_state_t;

endpackage

@@ hw/rtl/mrpa_if.sv @@
// Valid/ready channel interfaces for request entries and results.
interface mrpa_in_if import mrpa_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [TYPE_W-1:0]  req_type;
  logic [ID_W-1:0]    resource_id;
  logic [COUNT_W-1:0] amount;
  logic               last;

  modport source (output valid, req_type, resource_id, amount, last, input ready);
  modport sink   (input valid, req_type, resource_id, amount, last, output ready);
endinterface

interface mrpa_out_if;
  logic valid;
  logic ready;
  logic granted;
  logic saturated;
  logic bad_id;

  modport source (output valid, granted, saturated, bad_id, input ready);
  modport sink   (input valid, granted, saturated, bad_id, output ready);
endinterface

@@ hw/rtl/mrpa_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module mrpa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/mrpa_front.sv @@
// Front end: take request entries, classify the resource id, push into the queue.
module mrpa_front import mrpa_pkg::*; #(
  parameter int NUM_RESOURCES = NUM_RESOURCES_DEF
) (
  mrpa_in_if.sink    in_chan,
  input  fifo_stat_t stat,
  output logic       push,
  output entry_t     push_data
);

  logic [ID_W-1:0] id_m1;

  assign id_m1 = in_chan.resource_id - ID_W'(1);

  assign in_chan.ready = !stat.full;
  assign push          = in_chan.valid && !stat.full;

  always_comb begin
    push_data.req_type = in_chan.req_type;
    // Ids 1..NUM_RESOURCES map to slots 0..NUM_RESOURCES-1.
    push_data.known    = (in_chan.resource_id != '0) &&
                         (in_chan.resource_id <= ID_W'(NUM_RESOURCES));
    push_data.idx      = id_m1;
    push_data.amount   = in_chan.amount;
    push_data.last     = in_chan.last;
  end

endmodule

@@ hw/rtl/mrpa_fifo.sv @@
// Short entry queue between the front end and the back end.
module mrpa_fifo import mrpa_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  entry_t     push_data,
  input  logic       pop,
  output entry_t     head,
  output fifo_stat_t stat
);

  entry_t               mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CW-1:0]   cnt_r, cnt_nxt;
  logic                 do_push, do_pop;

  assign stat.full  = (cnt_r == FIFO_CW'(FIFO_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + FIFO_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + FIFO_AW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + FIFO_CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - FIFO_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ hw/rtl/mrpa_back.sv @@
// Back end: apply entries to the count store, check and take acquire demands, emit results.
module mrpa_back import mrpa_pkg::*; #(
  parameter int NUM_RESOURCES = NUM_RESOURCES_DEF,
  parameter int MAX_NEEDS     = MAX_NEEDS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  entry_t     head,
  input  fifo_stat_t stat,
  output logic       pop,
  mrpa_out_if.source out_chan
);

  localparam int IDX_W = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;
  localparam int PAW   = (MAX_NEEDS > 1) ? $clog2(MAX_NEEDS) : 1;
  localparam int CW    = $clog2(MAX_NEEDS + 1);

  back_state_t        state_r, state_nxt;
  entry_t             ent_r, ent_nxt;
  logic [CW-1:0]      pcnt_r, pcnt_nxt;
  logic [CW-1:0]      i_r, i_nxt, i_inc;
  logic [CW-1:0]      fail_r, fail_nxt;
  logic               ovf_r, ovf_nxt;
  logic               sat_r, sat_nxt;
  logic               bad_r, bad_nxt;
  logic               grant_r, grant_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_grant_r, out_grant_nxt;
  logic               out_sat_r, out_sat_nxt;
  logic               out_bad_r, out_bad_nxt;
  logic [NUM_RESOURCES-1:0] vld_r;
  logic               cnt_vld_q_r;

  logic               pw_en, pr_en;
  logic [PAW-1:0]     pw_addr, pr_addr;
  pend_t              pw_data, prd;

  logic               cr_en, cw_en;
  logic [IDX_W-1:0]   cr_addr, cw_addr;
  logic [COUNT_W-1:0] cw_data, cnt_rdata, cnt_q, have;
  logic [COUNT_W:0]   sum;

  mrpa_ram #(.WIDTH($bits(pend_t)), .DEPTH(MAX_NEEDS)) u_pend_ram (
    .clk   (clk),
    .we    (pw_en),
    .waddr (pw_addr),
    .wdata (pw_data),
    .re    (pr_en),
    .raddr (pr_addr),
    .rdata (prd)
  );

  mrpa_ram #(.WIDTH(COUNT_W), .DEPTH(NUM_RESOURCES)) u_count_ram (
    .clk   (clk),
    .we    (cw_en),
    .waddr (cw_addr),
    .wdata (cw_data),
    .re    (cr_en),
    .raddr (cr_addr),
    .rdata (cnt_rdata)
  );

  // A slot never written since reset reads as zero.
  assign cnt_q = cnt_vld_q_r ? cnt_rdata : '0;
  assign sum   = {1'b0, cnt_q} + {1'b0, ent_r.amount};
  assign have  = prd.known ? cnt_q : '0;
  assign i_inc = i_r + CW'(1);

  assign out_chan.valid     = out_valid_r;
  assign out_chan.granted   = out_grant_r;
  assign out_chan.saturated = out_sat_r;
  assign out_chan.bad_id    = out_bad_r;

  always_comb begin
    state_nxt     = state_r;
    ent_nxt       = ent_r;
    pcnt_nxt      = pcnt_r;
    i_nxt         = i_r;
    fail_nxt      = fail_r;
    ovf_nxt       = ovf_r;
    sat_nxt       = sat_r;
    bad_nxt       = bad_r;
    grant_nxt     = grant_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_grant_nxt = out_grant_r;
    out_sat_nxt   = out_sat_r;
    out_bad_nxt   = out_bad_r;
    pop           = 1'b0;
    pw_en         = 1'b0;
    pw_addr       = pcnt_r[PAW-1:0];
    pw_data       = '{known: head.known, idx: head.idx, amount: head.amount};
    pr_en         = 1'b0;
    pr_addr       = i_r[PAW-1:0];
    cr_en         = 1'b0;
    cr_addr       = head.idx[IDX_W-1:0];
    cw_en         = 1'b0;
    cw_addr       = ent_r.idx[IDX_W-1:0];
    cw_data       = '0;

    unique case (state_r)
      BK_FETCH: begin
        if (!stat.empty) begin
          pop     = 1'b1;
          ent_nxt = head;
          if (!head.known && head.req_type <= REQ_SET) begin
            bad_nxt = 1'b1;
          end
          state_nxt = head.last ? BK_START : BK_FETCH;
          case (head.req_type) inside
            REQ_ACQUIRE: begin
              if (pcnt_r < CW'(MAX_NEEDS)) begin
                pw_en    = 1'b1;
                pcnt_nxt = pcnt_r + CW'(1);
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            REQ_RELEASE, REQ_SET: begin
              if (head.known) begin
                cr_en     = 1'b1;
                state_nxt = BK_UPDATE;
              end
            end
            default: begin
            end
          endcase
        end
      end

      BK_UPDATE: begin
        cw_en = 1'b1;
        if (ent_r.req_type == REQ_SET) begin
          cw_data = ent_r.amount;
        end else if (sum[COUNT_W]) begin
          cw_data = '1;
          sat_nxt = 1'b1;
        end else begin
          cw_data = sum[COUNT_W-1:0];
        end
        state_nxt = ent_r.last ? BK_START : BK_FETCH;
      end

      BK_START: begin
        i_nxt = '0;
        if (ovf_r) begin
          grant_nxt = 1'b0;
          state_nxt = BK_DONE;
        end else if (pcnt_r == '0) begin
          grant_nxt = 1'b1;
          state_nxt = BK_DONE;
        end else begin
          pr_en     = 1'b1;
          pr_addr   = '0;
          state_nxt = BK_CHK_RD;
        end
      end

      BK_CHK_RD: begin
        cr_en     = prd.known;
        cr_addr   = prd.idx[IDX_W-1:0];
        state_nxt = BK_CHK_EX;
      end

      BK_CHK_EX: begin
        cw_addr = prd.idx[IDX_W-1:0];
        if (have < prd.amount) begin
          // Demand does not fit: put back what the earlier entries took.
          fail_nxt = i_r;
          i_nxt    = '0;
          if (i_r == '0) begin
            grant_nxt = 1'b0;
            state_nxt = BK_DONE;
          end else begin
            pr_en     = 1'b1;
            pr_addr   = '0;
            state_nxt = BK_UNDO_RD;
          end
        end else begin
          cw_en   = prd.known;
          cw_data = have - prd.amount;
          i_nxt   = i_inc;
          if (i_inc == pcnt_r) begin
            grant_nxt = 1'b1;
            state_nxt = BK_DONE;
          end else begin
            pr_en     = 1'b1;
            pr_addr   = i_inc[PAW-1:0];
            state_nxt = BK_CHK_RD;
          end
        end
      end

      BK_UNDO_RD: begin
        cr_en     = prd.known;
        cr_addr   = prd.idx[IDX_W-1:0];
        state_nxt = BK_UNDO_EX;
      end

      BK_UNDO_EX: begin
        cw_en   = prd.known;
        cw_addr = prd.idx[IDX_W-1:0];
        cw_data = cnt_q + prd.amount;
        i_nxt   = i_inc;
        if (i_inc == fail_r) begin
          grant_nxt = 1'b0;
          state_nxt = BK_DONE;
        end else begin
          pr_en     = 1'b1;
          pr_addr   = i_inc[PAW-1:0];
          state_nxt = BK_UNDO_RD;
        end
      end

      BK_DONE: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_grant_nxt = grant_r;
          out_sat_nxt   = sat_r;
          out_bad_nxt   = bad_r;
          pcnt_nxt      = '0;
          ovf_nxt       = 1'b0;
          sat_nxt       = 1'b0;
          bad_nxt       = 1'b0;
          state_nxt     = BK_FETCH;
        end
      end

      default: begin
        state_nxt = BK_FETCH;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_FETCH;
      pcnt_r      <= '0;
      ovf_r       <= 1'b0;
      sat_r       <= 1'b0;
      bad_r       <= 1'b0;
      out_valid_r <= 1'b0;
      vld_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      pcnt_r      <= pcnt_nxt;
      ovf_r       <= ovf_nxt;
      sat_r       <= sat_nxt;
      bad_r       <= bad_nxt;
      out_valid_r <= out_valid_nxt;
      if (cw_en) begin
        vld_r[cw_addr] <= 1'b1;
      end
    end
    if (cr_en) begin
      cnt_vld_q_r <= vld_r[cr_addr];
    end
    ent_r       <= ent_nxt;
    i_r         <= i_nxt;
    fail_r      <= fail_nxt;
    grant_r     <= grant_nxt;
    out_grant_r <= out_grant_nxt;
    out_sat_r   <= out_sat_nxt;
    out_bad_r   <= out_bad_nxt;
  end

endmodule

@@ hw/rtl/multi_resource_pool_allocator_unit.sv @@
// Multi-resource pool allocator: counting semaphores with all-or-nothing acquire.
//
// Channels: in_chan carries request entries (req_type, resource_id, amount,
// last); out_chan carries one result (granted, saturated, bad_id) for each
// request, produced by the entry that carries last. Both are valid/ready.
// Entries enter a four-deep queue; the back end drains it one entry at a time.
// Per entry in the back end: an acquire is written to the pending buffer, a
// release or set on a known id reads the count store, then writes it; other
// entries are only popped. After the final entry the back end walks the
// buffered acquire entries for the fit check and, on a refusal, walks the
// entries already taken to put them back. Both walks go through the
// registered read ports of the pending buffer and the count store, one entry
// at a time.
// Reset (synchronous, rst_n low) empties the queue, the pending buffer and the
// flags; the count store reads as zero through per-slot valid bits, so no
// clearing pass is needed. When the receiver stalls, the result holds in the
// output register; the back end waits with the next result while the queue
// keeps taking entries until it fills.
module multi_resource_pool_allocator_unit import mrpa_pkg::*; #(
  parameter int NUM_RESOURCES = NUM_RESOURCES_DEF,
  parameter int MAX_NEEDS     = MAX_NEEDS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  mrpa_in_if.sink    in_chan,
  mrpa_out_if.source out_chan
);

  logic       push;
  logic       pop;
  entry_t     push_data;
  entry_t     head;
  fifo_stat_t stat;

  // Classify ids and hand entries to the queue.
  mrpa_front #(.NUM_RESOURCES(NUM_RESOURCES)) u_front (
    .in_chan   (in_chan),
    .stat      (stat),
    .push      (push),
    .push_data (push_data)
  );

  // Decouple intake from execution.
  mrpa_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .stat      (stat)
  );

  // Execute entries against the count store and emit results.
  mrpa_back #(
    .NUM_RESOURCES (NUM_RESOURCES),
    .MAX_NEEDS     (MAX_NEEDS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .stat     (stat),
    .pop      (pop),
    .out_chan (out_chan)
  );

endmodule

@@ hw/rtl/mrpa_checker.sv @@
// Port-level checker for the pool allocator, bound to the top level.
`include "multi_resource_pool_allocator_unit_assert.svh"

module mrpa_checker import mrpa_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic in_last,
  input logic out_valid,
  input logic out_ready,
  input logic out_granted,
  input logic out_saturated,
  input logic out_bad_id
);

  localparam int OUTS_W = 4;

  // Requests whose last entry went in and whose result has not come out.
  logic [OUTS_W-1:0] outs_r, outs_nxt;
  logic              req_in, res_out;

  assign req_in  = in_valid && in_ready && in_last;
  assign res_out = out_valid && out_ready;

  always_comb begin
    outs_nxt = outs_r;
    if (req_in && !res_out) begin
      outs_nxt = outs_r + OUTS_W'(1);
    end else if (res_out && !req_in) begin
      outs_nxt = outs_r - OUTS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      outs_r <= '0;
    end else begin
      outs_r <= outs_nxt;
    end
  end

  // Hold a stalled result.
  `MRPA_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable({out_granted, out_saturated, out_bad_id}))

  // Show a result only for a request that ended.
  `MRPA_ASSERT_IMP(a_no_invented, out_valid, outs_r != '0)

  // Queue, back end and output register bound the requests in flight.
  `MRPA_ASSERT_IMP(a_bounded, 1'b1, outs_r <= OUTS_W'(FIFO_DEPTH + 2))

endmodule

bind multi_resource_pool_allocator_unit mrpa_checker u_mrpa_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_chan.valid),
  .in_ready      (in_chan.ready),
  .in_last       (in_chan.last),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .out_granted   (out_chan.granted),
  .out_saturated (out_chan.saturated),
  .out_bad_id    (out_chan.bad_id)
);
